/* rtl/bta_pkg.sv */
// Shared types and constants for the bakery ticket arbiter.
// No dependencies; imported by bta_cell and bakery_ticket_arbiter.
`timescale 1ns / 1ps

package bta_pkg;

   // Array sizing
   localparam int MAX_REQUESTERS = 16;
   localparam int TICKET_BITS    = 16;
   localparam int IDX_BITS       = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
   localparam int COUNT_BITS     = $clog2(MAX_REQUESTERS + 1);

   // Port field widths
   localparam int REQ_BITS    = 4;
   localparam int ISSUED_BITS = 16;
   localparam int CFG_BITS    = 5;
   localparam int STATUS_BITS = 3;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

   typedef logic [TICKET_BITS-1:0] ticket_type;

   localparam ticket_type TICKET_TOP = '1;

   // Operation codes
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_HOLDING   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NO_TICKET = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_RANGE     = 3'd4;

   // Scan token handed from cell to cell
   typedef struct packed {
      logic                valid;
      ticket_type          max_ticket;
      logic                min_valid;
      ticket_type          min_ticket;
      logic [IDX_BITS-1:0] min_index;
      logic                who_held;
   } wave_type;

   // Ticket write broadcast to all cells
   typedef struct packed {
      logic       enable;
      ticket_type value;
   } write_type;

endpackage

/* rtl/bta_cell.sv */
// One ticket slot of the arbiter chain: holds a ticket, folds it into the
// passing scan token and registers the token for its right neighbor. Uses bta_pkg.
`timescale 1ns / 1ps

module bta_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bta_pkg::IDX_BITS-1:0]   cell_index,
   input  logic [bta_pkg::COUNT_BITS-1:0] active_count,
   input  logic                           operation,
   input  logic [bta_pkg::REQ_BITS-1:0]   requester,
   input  bta_pkg::write_type             write_cmd,
   input  bta_pkg::wave_type              wave_in,
   output bta_pkg::wave_type              wave_out
);
   import bta_pkg::*;

   ticket_type ticket_ff;
   wave_type   wave_ff;
   wave_type   wave_in_fold;
   logic       is_active;
   logic       is_who;
   logic       excluded;

   assign is_active = COUNT_BITS'(cell_index) < active_count;
   assign is_who    = 32'(cell_index) == 32'(requester);
   // a successful release drops this slot from the grant search
   assign excluded  = is_who && (operation == OP_RELEASE);

   // fold this slot into the token
   always_comb begin
      wave_in_fold = wave_in;
      if (is_active) begin
         if (ticket_ff > wave_in.max_ticket) begin
            wave_in_fold.max_ticket = ticket_ff;
         end
         if (is_who && (ticket_ff != '0)) begin
            wave_in_fold.who_held = 1'b1;
         end
         if ((ticket_ff != '0) && !excluded &&
             (!wave_in.min_valid || (ticket_ff < wave_in.min_ticket))) begin
            wave_in_fold.min_valid  = 1'b1;
            wave_in_fold.min_ticket = ticket_ff;
            wave_in_fold.min_index  = cell_index;
         end
      end
   end

   // ticket storage and token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ticket_ff     <= '0;
         wave_ff.valid <= 1'b0;
      end else begin
         if (write_cmd.enable && is_who) begin
            ticket_ff <= write_cmd.value;
         end
         wave_ff.valid <= wave_in.valid;
      end
      wave_ff.max_ticket <= wave_in_fold.max_ticket;
      wave_ff.min_valid  <= wave_in_fold.min_valid;
      wave_ff.min_ticket <= wave_in_fold.min_ticket;
      wave_ff.min_index  <= wave_in_fold.min_index;
      wave_ff.who_held   <= wave_in_fold.who_held;
   end

   assign wave_out = wave_ff;

endmodule

/* rtl/bakery_ticket_arbiter.sv */
// Top level of the bakery ticket arbiter: control sequencer, output register
// and the row of bta_cell slots. Uses bta_pkg and bta_cell.
`timescale 1ns / 1ps
//
// Usage:
//   req_ channel (valid/ready) carries one operation: acquire or release for
//   one requester. rsp_ channel (valid/ready) returns one transaction per
//   request: issued ticket, current grant holder and a status code.
//   csr_write_enable / csr_write_data set the number of participating slots;
//   write it only while no request is in flight.
//   Each request sends a scan token down a chain of MAX_REQUESTERS cells, one
//   cell per cycle; the token collects the largest ticket and the grant
//   candidate. When the token leaves the chain it is captured in tail_ff;
//   the result is then resolved, the ticket written back and the response
//   registered, and a new request is taken only once the block is back to idle.
//   The response sits in an output register; a new request is accepted while
//   it waits. If the receiver still stalls when the next scan finishes, the
//   token is held until the output register frees up.
//   Reset clears all tickets, sets the slot count to 16 and drops rsp_valid.
//
module bakery_ticket_arbiter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [bta_pkg::REQ_BITS-1:0]    req_requester,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bta_pkg::ISSUED_BITS-1:0] rsp_ticket_issued,
   output logic [bta_pkg::REQ_BITS-1:0]    rsp_holder,
   output logic                            rsp_holder_valid,
   output logic [bta_pkg::STATUS_BITS-1:0] rsp_status,
   input  logic                            csr_write_enable,
   input  logic [bta_pkg::CFG_BITS-1:0]    csr_write_data
);
   import bta_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type               state_ff;
   logic [CFG_BITS-1:0]     cfg_ff;
   logic                    op_ff;
   logic [REQ_BITS-1:0]     who_ff;
   logic                    inject_ff;
   wave_type                tail_ff;
   logic                    rsp_valid_ff;
   logic [ISSUED_BITS-1:0]  issued_ff;
   logic [REQ_BITS-1:0]     holder_ff;
   logic                    holder_valid_ff;
   logic [STATUS_BITS-1:0]  status_ff;

   logic [COUNT_BITS-1:0]   active_count;
   wave_type                wave [MAX_REQUESTERS+1];
   write_type               write_cmd;
   logic                    finish;
   logic                    out_free;
   ticket_type              next_ticket;
   logic [31:0]             next_wide;
   logic [31:0]             holder_wide;
   logic [STATUS_BITS-1:0]  status_in;
   logic [ISSUED_BITS-1:0]  issued_in;
   logic [REQ_BITS-1:0]     holder_in;
   logic                    holder_valid_in;

   // clamp the slot count into 1 .. MAX_REQUESTERS
   always_comb begin
      if (cfg_ff == '0) begin
         active_count = COUNT_BITS'(1);
      end else if (32'(cfg_ff) > MAX_REQUESTERS) begin
         active_count = COUNT_BITS'(MAX_REQUESTERS);
      end else begin
         active_count = COUNT_BITS'(cfg_ff);
      end
   end

   // slot count register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         cfg_ff <= csr_write_data;
      end
   end

   // token entering the first cell
   always_comb begin
      wave[0]            = '0;
      wave[0].valid      = inject_ff;
   end

   // row of ticket slots
   for (genvar k = 0; k < MAX_REQUESTERS; k++) begin : g_cell
      bta_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (IDX_BITS'(k)),
         .active_count (active_count),
         .operation    (op_ff),
         .requester    (who_ff),
         .write_cmd    (write_cmd),
         .wave_in      (wave[k]),
         .wave_out     (wave[k+1])
      );
   end

   // resolve the finished scan
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign finish      = (state_ff == S_DONE) && out_free;
   assign next_ticket = tail_ff.max_ticket + ticket_type'(1);
   assign next_wide   = 32'(next_ticket);
   assign holder_wide = 32'(tail_ff.min_index);

   always_comb begin
      status_in       = ST_OK;
      issued_in       = '0;
      write_cmd       = '0;
      holder_in       = holder_wide[REQ_BITS-1:0];
      holder_valid_in = tail_ff.min_valid;
      if (32'(who_ff) >= 32'(active_count)) begin
         status_in = ST_RANGE;
      end else if (op_ff == OP_ACQUIRE) begin
         if (tail_ff.who_held) begin
            status_in = ST_HOLDING;
         end else if (tail_ff.max_ticket == TICKET_TOP) begin
            status_in = ST_OVERFLOW;
         end else begin
            issued_in       = next_wide[ISSUED_BITS-1:0];
            write_cmd.value = next_ticket;
            write_cmd.enable = finish;
            // new ticket is the largest, so it wins only when alone
            if (!tail_ff.min_valid) begin
               holder_in       = who_ff;
               holder_valid_in = 1'b1;
            end
         end
      end else begin
         if (!tail_ff.who_held) begin
            status_in = ST_NO_TICKET;
         end else begin
            write_cmd.enable = finish;
         end
      end
      if (!holder_valid_in) begin
         holder_in = '0;
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // token enters the chain the cycle after a request is taken
         inject_ff <= (state_ff == S_IDLE) && req_valid;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff  <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (wave[MAX_REQUESTERS].valid) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (req_valid && req_ready) begin
         op_ff  <= req_operation;
         who_ff <= req_requester;
      end
      if (state_ff == S_SCAN && wave[MAX_REQUESTERS].valid) begin
         tail_ff <= wave[MAX_REQUESTERS];
      end
      if (finish) begin
         issued_ff       <= issued_in;
         holder_ff       <= holder_in;
         holder_valid_ff <= holder_valid_in;
         status_ff       <= status_in;
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ticket_issued = issued_ff;
   assign rsp_holder        = holder_ff;
   assign rsp_holder_valid  = holder_valid_ff;
   assign rsp_status        = status_ff;

   // checks
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a scan is in flight");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      wave[MAX_REQUESTERS].valid |-> (state_ff == S_SCAN))
      else $error("scan token left the chain outside a scan");

   a_refused_no_ticket: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_ticket_issued == '0))
      else $error("ticket issued on a refused transaction");

   a_idle_holder_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_holder_valid) |-> (rsp_holder == '0))
      else $error("holder nonzero with no grant");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the bakery ticket arbiter: directed table and
// random acquire/release traffic, all scored in-line.
// Depends on bta_pkg and bakery_ticket_arbiter.
`timescale 1ns / 1ps

module tb;
   import bta_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int QUIET_LIMIT  = 4000;   // cycles with no transaction at all
   localparam int PHASE_ITEMS  = 250;
   localparam int MAX_PRINTS   = 40;
   localparam int DRAIN_CYCLES = 40;

   // One response transaction
   typedef struct packed {
      logic [ISSUED_BITS-1:0] issued;
      logic [REQ_BITS-1:0]    holder;
      logic                   holder_valid;
      logic [STATUS_BITS-1:0] status;
   } grant_type;

   typedef enum logic {ROW_OP, ROW_CSR} row_kind_type;

   // One line of the directed table
   typedef struct packed {
      row_kind_type        kind;
      logic [CFG_BITS-1:0] csr_value;
      logic                op;
      logic [REQ_BITS-1:0] who;
      logic                typed;
      grant_type           want;
   } script_row_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic                   req_operation    = OP_ACQUIRE;
   logic [REQ_BITS-1:0]    req_requester    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [ISSUED_BITS-1:0] rsp_ticket_issued;
   logic [REQ_BITS-1:0]    rsp_holder;
   logic                   rsp_holder_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   logic                   csr_write_enable = 1'b0;
   logic [CFG_BITS-1:0]    csr_write_data   = '0;

   // Predictor state: ticket per slot and the slot-count register
   ticket_type          model_tickets [MAX_REQUESTERS];
   logic [CFG_BITS-1:0] model_slots_reg;
   grant_type           expected_grants [$];

   int mismatches    = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   bakery_ticket_arbiter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_requester     (req_requester),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ticket_issued (rsp_ticket_issued),
      .rsp_holder        (rsp_holder),
      .rsp_holder_valid  (rsp_holder_valid),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Zero acts as one slot, anything above the array size as the full array
   function automatic int unsigned slots_taking_part();
      if (model_slots_reg == 0) return 1;
      if (model_slots_reg > MAX_REQUESTERS) return MAX_REQUESTERS;
      return 32'(model_slots_reg);
   endfunction

   function automatic ticket_type highest_ticket();
      ticket_type   top;
      int unsigned  n;
      top = '0;
      n   = slots_taking_part();
      for (int k = 0; k < n; k++)
         if (model_tickets[k] > top) top = model_tickets[k];
      return top;
   endfunction

   // Apply one operation to the ticket store and return the resulting grant
   function automatic grant_type grant_after(logic op, logic [REQ_BITS-1:0] who);
      grant_type   g;
      int unsigned n;
      ticket_type  top;
      ticket_type  low;
      g   = '0;
      low = '0;
      n   = slots_taking_part();
      g.status = ST_OK;
      if (who >= n) begin
         g.status = ST_RANGE;
      end else if (op == OP_ACQUIRE) begin
         if (model_tickets[who] != 0) begin
            g.status = ST_HOLDING;
         end else begin
            top = highest_ticket();
            if (top == TICKET_TOP) begin
               g.status = ST_OVERFLOW;
            end else begin
               model_tickets[who] = top + 1'b1;
               g.issued           = top + 1'b1;
            end
         end
      end else if (model_tickets[who] == 0) begin
         g.status = ST_NO_TICKET;
      end else begin
         model_tickets[who] = '0;
      end
      // grant: smallest nonzero ticket, lower index wins a tie
      for (int k = 0; k < n; k++) begin
         if (model_tickets[k] != 0 && (!g.holder_valid || model_tickets[k] < low)) begin
            g.holder_valid = 1'b1;
            low            = model_tickets[k];
            g.holder       = REQ_BITS'(k);
         end
      end
      return g;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] expv, logic [31:0] gotv);
      if (mismatches < MAX_PRINTS)
         $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, expv, gotv);
      mismatches++;
   endtask

   // Drive one request transaction; the expectation is queued at acceptance
   task automatic send_op(logic op, logic [REQ_BITS-1:0] who, logic typed, grant_type want);
      grant_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_operation = op;
      req_requester = who;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = grant_after(op, who);
      expected_grants.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain();
      req_valid = 1'b0;
      while (expected_grants.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CFG_BITS-1:0] value);
      drain();
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      model_slots_reg  = value;
   endtask

   // Mostly well-formed acquire/release pairs, some ignored or flagged requests
   task automatic random_phase(logic [CFG_BITS-1:0] slots, int s_pct, int r_pct);
      int unsigned         n;
      logic                op;
      logic [REQ_BITS-1:0] who;
      write_csr(slots);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         n = slots_taking_part();
         if ($urandom_range(0, 99) < 80) begin
            who = REQ_BITS'($urandom_range(0, n - 1));
            op  = (model_tickets[who] == 0) ? OP_ACQUIRE : OP_RELEASE;
         end else begin
            who = REQ_BITS'($urandom_range(0, MAX_REQUESTERS - 1));
            op  = 1'($urandom_range(0, 1));
         end
         send_op(op, who, 1'b0, '0);
      end
   endtask

   function automatic script_row_type op_row(logic op, logic [REQ_BITS-1:0] who);
      script_row_type r;
      r       = '0;
      r.kind  = ROW_OP;
      r.op    = op;
      r.who   = who;
      return r;
   endfunction

   function automatic script_row_type checked_row(logic op, logic [REQ_BITS-1:0] who,
                                                  logic [ISSUED_BITS-1:0] issued,
                                                  logic [REQ_BITS-1:0] holder,
                                                  logic hvalid,
                                                  logic [STATUS_BITS-1:0] status);
      script_row_type r;
      r       = op_row(op, who);
      r.typed = 1'b1;
      r.want  = '{issued: issued, holder: holder, holder_valid: hvalid, status: status};
      return r;
   endfunction

   function automatic script_row_type csr_row(logic [CFG_BITS-1:0] value);
      script_row_type r;
      r           = '0;
      r.kind      = ROW_CSR;
      r.csr_value = value;
      return r;
   endfunction

   // Receiver: random back-pressure, decided at the falling edge
   always @(negedge clock)
      if (!reset) rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);

   // Response scoreboard
   always @(posedge clock) begin : response_check
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            report_mismatch("response with nothing pending", 0, 1);
         end else begin
            want = expected_grants.pop_front();
            if (rsp_ticket_issued !== want.issued)
               report_mismatch("ticket_issued", 32'(want.issued), 32'(rsp_ticket_issued));
            if (rsp_holder !== want.holder)
               report_mismatch("holder", 32'(want.holder), 32'(rsp_holder));
            if (rsp_holder_valid !== want.holder_valid)
               report_mismatch("holder_valid", 32'(want.holder_valid),
                               32'(rsp_holder_valid));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   // Watchdog: too long without any transaction ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      script_row_type script [$];
      for (int k = 0; k < MAX_REQUESTERS; k++) model_tickets[k] = '0;
      model_slots_reg = CFG_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: reset state, error codes, register extremes, shrink/regrow
      script.push_back(checked_row(OP_ACQUIRE, 0,  1, 0,  1'b1, ST_OK));
      script.push_back(checked_row(OP_ACQUIRE, 0,  0, 0,  1'b1, ST_HOLDING));
      script.push_back(checked_row(OP_RELEASE, 15, 0, 0,  1'b1, ST_NO_TICKET));
      script.push_back(checked_row(OP_ACQUIRE, 15, 2, 0,  1'b1, ST_OK));
      script.push_back(checked_row(OP_RELEASE, 0,  0, 15, 1'b1, ST_OK));
      script.push_back(checked_row(OP_RELEASE, 15, 0, 0,  1'b0, ST_OK));
      script.push_back(checked_row(OP_RELEASE, 15, 0, 0,  1'b0, ST_NO_TICKET));
      script.push_back(csr_row(0));                      // zero acts as one slot
      script.push_back(checked_row(OP_ACQUIRE, 1,  0, 0,  1'b0, ST_RANGE));
      script.push_back(checked_row(OP_RELEASE, 15, 0, 0,  1'b0, ST_RANGE));
      script.push_back(checked_row(OP_ACQUIRE, 0,  1, 0,  1'b1, ST_OK));
      script.push_back(csr_row(31));                     // clamps to full array
      script.push_back(op_row(OP_ACQUIRE, 15));
      script.push_back(op_row(OP_ACQUIRE, 7));
      script.push_back(csr_row(4));                      // shrink: 7 and 15 keep tickets
      script.push_back(op_row(OP_ACQUIRE, 2));
      script.push_back(op_row(OP_RELEASE, 0));
      script.push_back(checked_row(OP_ACQUIRE, 7,  0, 2,  1'b1, ST_RANGE));
      script.push_back(csr_row(16));                     // regrow, tie between 2 and 15
      script.push_back(op_row(OP_ACQUIRE, 3));
      script.push_back(op_row(OP_RELEASE, 2));
      script.push_back(csr_row(1));
      script.push_back(op_row(OP_ACQUIRE, 0));
      script.push_back(csr_row(16));
      script.push_back(checked_row(OP_ACQUIRE, 0,  0, 0,  1'b1, ST_HOLDING));

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR)
            write_csr(script[i].csr_value);
         else
            send_op(script[i].op, script[i].who, script[i].typed, script[i].want);
      end

      // Random traffic under three back-pressure profiles
      random_phase(16, 9, 84);
      random_phase(CFG_BITS'($urandom_range(2, 15)), 84, 9);
      random_phase(31, 0, 0);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
